### hdl/irdl_pkg.sv
// ----------------------------------------------------------------------------
// irdl_pkg
// Shared types, tables and constants of the IR distance linearizer.
// ----------------------------------------------------------------------------
package irdl_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int CH_W         = 2;
  localparam int SAMPLE_W     = 12;
  localparam int DIST_W       = 8;
  localparam int NUM_SEGS     = 12;
  localparam int NUM_PTS      = NUM_SEGS + 1;
  localparam int SEG_W        = $clog2(NUM_SEGS);
  localparam int DY_W         = 4;
  localparam int DX_W         = 11;
  localparam int D0_W         = 7;
  localparam int PROD_W       = SAMPLE_W + DY_W;
  localparam int QDEPTH       = 2;

  localparam logic [DIST_W-1:0] MIN_DIST_RST = 8'd10;
  localparam logic [DIST_W-1:0] PREV_RST     = 8'd10;

  // Falling converter breakpoints
  localparam logic [SAMPLE_W-1:0] ADC_PTS [NUM_PTS] = '{
    12'd4095, 12'd3775, 12'd2400, 12'd1770, 12'd1330, 12'd1064, 12'd915,
    12'd805,  12'd740,  12'd700,  12'd630,  12'd590,  12'd560
  };

  // Per segment: start distance, distance step, converter span
  localparam logic [D0_W-1:0] SEG_D0 [NUM_SEGS] = '{
    7'd0, 7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45, 7'd50,
    7'd55, 7'd60
  };
  localparam logic [DY_W-1:0] SEG_DY [NUM_SEGS] = '{
    4'd10, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5
  };
  localparam logic [DX_W-1:0] SEG_DX [NUM_SEGS] = '{
    11'd320, 11'd1375, 11'd630, 11'd440, 11'd266, 11'd149, 11'd110,
    11'd65,  11'd40,   11'd70,  11'd40,  11'd30
  };

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_channel;
    logic [DIST_W-1:0] distance;
  } out_item_t;

  // Work handed from the front end to the divide back end
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [SEG_W-1:0]  seg;
    logic [PROD_W-1:0] prod;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } bk_state_t;

endpackage

### hdl/ir_distance_linearizer_core.sv
// ----------------------------------------------------------------------------
// ir_distance_linearizer_core
// IR sensor sample to smoothed distance, by piecewise linear table lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue write side: drive in_data (channel, sample) and in_push;
//   a transfer happens on a clock edge with in_push high and in_full low.
//   Items on channel 3 are taken and dropped without a result.
//   Results come out of a queue read side: while out_empty is low, out_data
//   holds the oldest result; a transfer happens with out_pop high.
//   min_distance is written over cfg_valid/cfg_data (cfg_ready is always
//   high); write it only while the block is idle.
// Timing:
//   The front end takes an item per cycle into a 2-entry job queue while it
//   is not full. The back end works on one job at a time: it fetches a job,
//   runs the bit-serial divide by the segment span (one quotient bit per
//   cycle), then finishes.
// Reset (rst_n low, synchronous): queue and output emptied, per-channel
//   segments cleared to 0, last distances and min_distance set to 10.
// A stalled receiver holds the result register; the back end then waits in
//   its finish step and, once the job queue fills, in_full goes high.
// ----------------------------------------------------------------------------
module ir_distance_linearizer_core import irdl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  in_item_t          in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DIST_W-1:0] cfg_data
);

  logic [DIST_W-1:0] min_dist_r;

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  job_t    q_wdata;
  job_t    q_rdata;

  // Config register: always ready, one transfer per cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_dist_r <= cfg_data;
    end
  end

  // Front end: segment search and numerator product
  irdl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // Decoupling queue
  irdl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back end: divide, clamp, smooth, hold result
  irdl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .min_dist  (min_dist_r),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  // Front end never writes a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // Back end never reads an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  // Dropped channels must not produce a job
  a_drop_bad_ch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_data.channel >= CH_W'(NUM_CHANNELS)) |-> !q_push)
    else $error("job queued for unused channel");

  // A waiting result is not overwritten while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

### hdl/irdl_front.sv
// ----------------------------------------------------------------------------
// irdl_front
// Accepts samples, finds the table segment, forms the interpolation product.
// ----------------------------------------------------------------------------
module irdl_front import irdl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output job_t     q_wdata
);

  logic [SEG_W-1:0] seg_r [NUM_CHANNELS];

  logic                ch_ok;
  logic [CH_W-1:0]     ch_idx;
  logic                hit;
  logic [SEG_W-1:0]    hit_idx;
  logic [SEG_W-1:0]    seg_cur;
  logic [SAMPLE_W-1:0] num;
  logic [SAMPLE_W-1:0] a_hi;

  assign in_full = q_stat.full;
  assign ch_ok   = (in_data.channel < CH_W'(NUM_CHANNELS));
  assign ch_idx  = ch_ok ? in_data.channel : '0;
  assign q_push  = in_push && !q_stat.full && ch_ok;

  // Segments are disjoint, so at most one compare pair fires
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < NUM_SEGS; i++) begin
      if (in_data.sample <= ADC_PTS[i] && in_data.sample > ADC_PTS[i+1]) begin
        hit     = 1'b1;
        hit_idx = SEG_W'(i);
      end
    end
  end

  assign seg_cur = hit ? hit_idx : seg_r[ch_idx];
  assign a_hi    = ADC_PTS[seg_cur];
  assign num     = (a_hi >= in_data.sample) ? (a_hi - in_data.sample) : '0;

  always_comb begin
    q_wdata.ch   = ch_idx;
    q_wdata.seg  = seg_cur;
    q_wdata.prod = PROD_W'(num) * PROD_W'(SEG_DY[seg_cur]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        seg_r[c] <= '0;
      end
    end else if (q_push && hit) begin
      seg_r[ch_idx] <= hit_idx;
    end
  end

endmodule

### hdl/irdl_queue.sv
// ----------------------------------------------------------------------------
// irdl_queue
// Short FIFO of jobs between front end and back end.
// ----------------------------------------------------------------------------
module irdl_queue import irdl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    wdata,
  input  logic    pop,
  output job_t    rdata,
  output q_stat_t stat
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r;
  logic           do_push, do_pop;

  assign stat.full  = (cnt_r == QCW'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### hdl/irdl_back.sv
// ----------------------------------------------------------------------------
// irdl_back
// Serial divide by segment span, offset, clamp, smoothing, output register.
// ----------------------------------------------------------------------------
module irdl_back import irdl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DIST_W-1:0] min_dist,
  input  q_stat_t           q_stat,
  input  job_t              q_rdata,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output out_item_t         out_data
);

  localparam int CNT_W = $clog2(PROD_W);

  bk_state_t         state_r, state_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [SEG_W-1:0]  seg_r, seg_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [DX_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_vld_r, out_vld_nxt;
  out_item_t         out_r, out_nxt;
  logic [DIST_W-1:0] prev_r [NUM_CHANNELS];
  logic              prev_we;

  logic [DX_W:0]     trial;
  logic [DX_W:0]     dx_ext;
  logic              qbit;
  logic [PROD_W:0]   v;
  logic [DIST_W-1:0] v_sat;
  logic [DIST_W-1:0] calc;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] avg;
  logic              out_free;

  assign out_empty = !out_vld_r;
  assign out_data  = out_r;
  assign out_free  = !out_vld_r || out_pop;

  // One restoring-divide step: remainder stays below the span
  assign dx_ext = {1'b0, SEG_DX[seg_r]};
  assign trial  = {rem_r, quo_r[PROD_W-1]};
  assign qbit   = (trial >= dx_ext);

  // Offset, saturate, clamp, average with the channel's last output
  assign v     = (PROD_W+1)'(SEG_D0[seg_r]) + (PROD_W+1)'(quo_r);
  assign v_sat = (v > (PROD_W+1)'(8'hFF)) ? 8'hFF : v[DIST_W-1:0];
  assign calc  = (v_sat < min_dist) ? min_dist : v_sat;
  assign sum   = {1'b0, prev_r[ch_r]} + {1'b0, calc};
  assign avg   = sum[DIST_W:1];

  always_comb begin
    state_nxt   = state_r;
    ch_nxt      = ch_r;
    seg_nxt     = seg_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r && !out_pop;
    out_nxt     = out_r;
    q_pop       = 1'b0;
    prev_we     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          ch_nxt    = q_rdata.ch;
          seg_nxt   = q_rdata.seg;
          quo_nxt   = q_rdata.prod;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        rem_nxt = qbit ? DX_W'(trial - dx_ext) : trial[DX_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        if (out_free) begin
          out_vld_nxt         = 1'b1;
          out_nxt.out_channel = ch_r;
          out_nxt.distance    = avg;
          prev_we             = 1'b1;
          state_nxt           = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r  <= ch_nxt;
    seg_r <= seg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        prev_r[c] <= PREV_RST;
      end
    end else if (prev_we) begin
      prev_r[ch_r] <= avg;
    end
  end

endmodule
